### rtl/bbspi_pkg.sv
// Package for the bit-banged SPI master: command and clock phase codes,
// request and response word types.
// No dependencies; imported by bitbang_spi_master.
package bbspi_pkg;

	// Request commands
	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_PUSH = 2'd1,
		CMD_ARM  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	// Four-phase serial clock
	typedef enum logic [1:0] {
		PH_RISE = 2'd0,
		PH_HIGH = 2'd1,
		PH_FALL = 2'd2,
		PH_LOW  = 2'd3
	} phase_t;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned BIT_W  = 4;

	typedef struct packed {
		logic [1:0]        command;
		logic              sclk_readback;
		logic              miso;
		logic [BYTE_W-1:0] tx_byte;
		logic              tx_last;
		logic [BYTE_W-1:0] rx_length;
	} req_word_t;

	typedef struct packed {
		logic              sclk;
		logic              mosi;
		logic [BYTE_W-1:0] rx_byte;
		logic              rx_valid;
		logic              rx_done;
		logic              tx_done;
		logic              clock_error;
		logic              tx_busy;
	} rsp_word_t;

endpackage

### rtl/bbspi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the send queue of bitbang_spi_master.
module bbspi_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/bitbang_spi_master.sv
// Bit-banged SPI master, mode 1, LSB first, driven one tick per request word.
// Each response word is registered, valid in the cycle after its request is accepted.
// Throughput: one request word per cycle unless a held response stalls it;
// the queue RAM is read each cycle at the head, a dequeued byte taken from
// its registered output. Reset clears all control state; queue contents stay
// undefined until written, needing no clearing as only filled ones are loaded.
module bitbang_spi_master #(
	parameter int unsigned SEND_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  bbspi_pkg::req_word_t  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output bbspi_pkg::rsp_word_t  rsp
);
	import bbspi_pkg::*;

	localparam int unsigned PTR_W  = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(SEND_DEPTH + 1);
	localparam int unsigned SUM_W  = PTR_W + 1;

	// Control and data state
	phase_t              phase_q, phase_d;
	logic [BIT_W-1:0]    bit_idx_q, bit_idx_d;
	logic [BYTE_W-1:0]   tx_shift_q, tx_shift_d, tx_shift_cur;
	logic [BYTE_W-1:0]   rx_shift_q, rx_shift_d, rx_shift_upd;
	logic [PTR_W-1:0]    head_q, head_d;
	logic [FILL_W-1:0]   fill_q, fill_d;
	logic [BYTE_W-1:0]   rx_target_q, rx_target_d;
	logic [BYTE_W-1:0]   rx_count_q, rx_count_d;
	logic                tx_run_q, tx_run_d;
	logic                rx_run_q, rx_run_d;
	logic                tx_busy_q, tx_busy_d;
	logic                rx_busy_q, rx_busy_d;
	logic                err_q, err_d;
	logic                mosi_q, mosi_d;
	logic                sclk_q, sclk_d;
	logic                load_pend_q, load_pend_d;

	// Response register
	logic                rsp_valid_q;
	rsp_word_t           rsp_q, rsp_d;

	// Queue RAM signals
	logic                wr_en;
	logic [PTR_W-1:0]    wr_addr;
	logic [SUM_W-1:0]    wr_sum;
	logic [BYTE_W-1:0]   rd_data;

	logic                accept;
	logic                tick;
	logic                stop;
	logic [2:0]          bit_sel;

	assign accept    = req_valid && !req_stall;
	assign req_stall = rsp_valid_q && rsp_stall;
	assign bit_sel   = bit_idx_q[2:0];

	// Tail address: head plus fill, wrapped once
	always_comb begin
		wr_sum = SUM_W'(head_q) + SUM_W'(fill_q);
		if (wr_sum >= SUM_W'(SEND_DEPTH)) begin
			wr_sum = wr_sum - SUM_W'(SEND_DEPTH);
		end
		wr_addr = wr_sum[PTR_W-1:0];
	end

	bbspi_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (SEND_DEPTH)
	) u_queue (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (req.tx_byte),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	// A byte dequeued last cycle arrives from the RAM now
	assign tx_shift_cur = load_pend_q ? rd_data : tx_shift_q;

	// Decide whether this word advances the clock
	always_comb begin
		tick = accept && !err_q && (cmd_t'(req.command) == CMD_TICK);
		stop = 1'b0;
		if (tick) begin
			unique case (phase_q)
				PH_HIGH: stop = (req.sclk_readback != 1'b1);
				PH_LOW:  stop = (req.sclk_readback != 1'b0);
				default: stop = 1'b0;
			endcase
		end
	end

	// Next clock phase
	always_comb begin
		phase_d = phase_q;
		if (tick && !stop) begin
			unique case (phase_q)
				PH_RISE: phase_d = PH_HIGH;
				PH_HIGH: phase_d = PH_FALL;
				PH_FALL: phase_d = PH_LOW;
				PH_LOW:  phase_d = PH_RISE;
				default: phase_d = PH_RISE;
			endcase
		end
	end

	// Datapath and outputs: queue, shifters, frame control, response word
	always_comb begin
		bit_idx_d    = bit_idx_q;
		tx_shift_d   = tx_shift_cur;
		rx_shift_d   = rx_shift_q;
		rx_shift_upd = rx_shift_q;
		head_d       = head_q;
		fill_d       = fill_q;
		rx_target_d  = rx_target_q;
		rx_count_d   = rx_count_q;
		tx_run_d     = tx_run_q;
		rx_run_d     = rx_run_q;
		tx_busy_d    = tx_busy_q;
		rx_busy_d    = rx_busy_q;
		err_d        = err_q;
		mosi_d       = mosi_q;
		sclk_d       = sclk_q;
		load_pend_d  = 1'b0;
		wr_en        = 1'b0;
		rsp_d        = '0;

		if (accept && !err_q) begin
			unique case (cmd_t'(req.command))
				CMD_PUSH: begin
					if (!tx_busy_q) begin
						if (fill_q < FILL_W'(SEND_DEPTH)) begin
							wr_en  = 1'b1;
							fill_d = fill_q + FILL_W'(1);
						end
						if (req.tx_last) begin
							tx_busy_d = 1'b1;
						end
					end
				end
				CMD_ARM: begin
					if (!rx_busy_q) begin
						rx_target_d = req.rx_length;
						rx_count_d  = '0;
						rx_busy_d   = 1'b1;
					end
				end
				CMD_TICK: begin
					if (stop) begin
						err_d = 1'b1;
					end else begin
						unique case (phase_q)
							PH_RISE: begin
								sclk_d = 1'b1;
								if (bit_idx_q == '0) begin
									// Frame start: sender
									if (tx_busy_q) begin
										if (fill_q == '0) begin
											rsp_d.tx_done = 1'b1;
											tx_busy_d     = 1'b0;
											tx_run_d      = 1'b0;
										end else begin
											load_pend_d = 1'b1;
											head_d      = (head_q == PTR_W'(SEND_DEPTH - 1)) ?
												'0 : head_q + PTR_W'(1);
											fill_d      = fill_q - FILL_W'(1);
											tx_run_d    = 1'b1;
										end
									end
									// Frame start: receiver
									if (rx_busy_q) begin
										if (rx_count_q >= rx_target_q) begin
											rsp_d.rx_done = 1'b1;
											rx_busy_d     = 1'b0;
											rx_run_d      = 1'b0;
											rx_count_d    = '0;
										end else begin
											rx_run_d = 1'b1;
										end
									end
								end
							end
							PH_HIGH: begin
								if (tx_run_q) begin
									mosi_d = tx_shift_cur[bit_sel];
								end
							end
							PH_FALL: begin
								sclk_d = 1'b0;
							end
							PH_LOW: begin
								if (rx_run_q) begin
									rx_shift_upd           = rx_shift_q;
									rx_shift_upd[bit_sel]  = rx_shift_q[bit_sel] | req.miso;
									rx_shift_d             = rx_shift_upd;
								end
								bit_idx_d = bit_idx_q + BIT_W'(1);
							end
							default: begin
							end
						endcase

						// Close the byte frame after the eighth bit period
						if (bit_idx_d >= BIT_W'(BYTE_W)) begin
							if (rx_run_q) begin
								rsp_d.rx_byte  = rx_shift_upd;
								rsp_d.rx_valid = 1'b1;
								rx_count_d     = rx_count_q + BYTE_W'(1);
							end
							tx_run_d   = 1'b0;
							rx_run_d   = 1'b0;
							tx_shift_d = '0;
							rx_shift_d = '0;
							bit_idx_d  = '0;
						end
					end
				end
				default: begin
				end
			endcase
		end

		rsp_d.sclk        = sclk_d;
		rsp_d.mosi        = mosi_d;
		rsp_d.clock_error = err_d;
		rsp_d.tx_busy     = tx_busy_d;
	end

	// Control state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_RISE;
			bit_idx_q   <= '0;
			tx_shift_q  <= '0;
			rx_shift_q  <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			rx_target_q <= '0;
			rx_count_q  <= '0;
			tx_run_q    <= 1'b0;
			rx_run_q    <= 1'b0;
			tx_busy_q   <= 1'b0;
			rx_busy_q   <= 1'b0;
			err_q       <= 1'b0;
			mosi_q      <= 1'b0;
			sclk_q      <= 1'b0;
			load_pend_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			bit_idx_q   <= bit_idx_d;
			tx_shift_q  <= tx_shift_d;
			rx_shift_q  <= rx_shift_d;
			head_q      <= head_d;
			fill_q      <= fill_d;
			rx_target_q <= rx_target_d;
			rx_count_q  <= rx_count_d;
			tx_run_q    <= tx_run_d;
			rx_run_q    <= rx_run_d;
			tx_busy_q   <= tx_busy_d;
			rx_busy_q   <= rx_busy_d;
			err_q       <= err_d;
			mosi_q      <= mosi_d;
			sclk_q      <= sclk_d;
			load_pend_q <= load_pend_d;
		end
	end

	// Response valid: set on accept, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response word: hold while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Queue never overfills
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(SEND_DEPTH))
		else $error("send queue fill beyond depth");

	// A dequeued byte is only ever pending right after the rise phase
	a_load_phase: assert property (@(posedge clk) disable iff (!arst_n)
		load_pend_q |-> (phase_q == PH_HIGH))
		else $error("queue load pending outside high phase");

	// Clock error is sticky
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("clock error cleared");

	// Bit index wraps at the byte boundary
	a_bit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		bit_idx_q < BIT_W'(BYTE_W))
		else $error("bit index out of range");

	// Sender only shifts out while a transfer is armed
	a_tx_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tx_run_q |-> tx_busy_q)
		else $error("sender running while not busy");

endmodule

### verif/tb_bitbang_spi_master.sv
// Self-checking testbench for bitbang_spi_master: random and directed request words,
// response words checked against a cycle-free line tracker of the SPI master.
// Depends on bbspi_pkg and the bitbang_spi_master RTL.
module tb_bitbang_spi_master;
	timeunit 1ns;
	timeprecision 1ps;

	import bbspi_pkg::*;

	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int          PHASE_WORDS = 60;

	// Track the master's lines and queues; hold the responses still to arrive
	class spi_line_tracker;
		phase_t          ph;
		logic [3:0]      bit_idx;
		logic [7:0]      tx_sh;
		logic [7:0]      rx_sh;
		logic [7:0]      queue_mem [QUEUE_DEPTH];
		int unsigned     head;
		int unsigned     fill;
		logic [7:0]      rx_tgt;
		logic [7:0]      rx_cnt;
		bit              tx_run, rx_run, tx_busy, rx_busy, err, mosi_q, sclk_q;
		rsp_word_t       expected_rsp [$];
		int              mismatches;
		int              checked;
		int              rx_bytes;
		int              tx_dones;
		int              rx_dones;

		function new();
			ph = PH_RISE;
			bit_idx = '0;
			tx_sh = '0;
			rx_sh = '0;
			head = 0;
			fill = 0;
			rx_tgt = '0;
			rx_cnt = '0;
			mismatches = 0;
			checked = 0;
			rx_bytes = 0;
			tx_dones = 0;
			rx_dones = 0;
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		// Advance the tracked state by one request word and return its response
		function rsp_word_t predict(req_word_t r);
			rsp_word_t o;
			bit        halt;
			o = '0;
			halt = 1'b0;
			if (!err) begin
				case (cmd_t'(r.command))
					CMD_PUSH: if (!tx_busy) begin
						// drop the byte when full, but still honour the last mark
						if (fill < QUEUE_DEPTH) begin
							queue_mem[(head + fill) % QUEUE_DEPTH] = r.tx_byte;
							fill++;
						end
						if (r.tx_last)
							tx_busy = 1'b1;
					end
					CMD_ARM: if (!rx_busy) begin
						rx_tgt = r.rx_length;
						rx_cnt = '0;
						rx_busy = 1'b1;
					end
					CMD_TICK: begin
						case (ph)
							PH_RISE: begin
								sclk_q = 1'b1;
								// frame start: load the next byte or report a drained queue
								if (bit_idx == 4'd0) begin
									if (tx_busy) begin
										if (fill == 0) begin
											o.tx_done = 1'b1;
											tx_busy = 1'b0;
											tx_run = 1'b0;
											tx_dones++;
										end else begin
											tx_sh = queue_mem[head];
											head = (head + 1) % QUEUE_DEPTH;
											fill--;
											tx_run = 1'b1;
										end
									end
									if (rx_busy) begin
										if (rx_cnt >= rx_tgt) begin
											o.rx_done = 1'b1;
											rx_busy = 1'b0;
											rx_run = 1'b0;
											rx_cnt = '0;
											rx_dones++;
										end else begin
											rx_run = 1'b1;
										end
									end
								end
							end
							PH_HIGH: begin
								if (r.sclk_readback !== 1'b1) begin
									err = 1'b1;
									halt = 1'b1;
								end else if (tx_run) begin
									mosi_q = tx_sh[bit_idx[2:0]];
								end
							end
							PH_FALL: sclk_q = 1'b0;
							default: begin
								if (r.sclk_readback !== 1'b0) begin
									err = 1'b1;
									halt = 1'b1;
								end else begin
									if (rx_run)
										rx_sh[bit_idx[2:0]] = rx_sh[bit_idx[2:0]] | r.miso;
									bit_idx++;
								end
							end
						endcase
						// advance the phase and close the byte frame after eight bits
						if (!halt) begin
							ph = phase_t'(ph + 2'd1);
							if (bit_idx >= 4'd8) begin
								if (rx_run) begin
									o.rx_byte = rx_sh;
									o.rx_valid = 1'b1;
									rx_cnt++;
									rx_bytes++;
								end
								tx_run = 1'b0;
								rx_run = 1'b0;
								tx_sh = '0;
								rx_sh = '0;
								bit_idx = '0;
							end
						end
					end
					default: ;
				endcase
			end
			o.sclk = sclk_q;
			o.mosi = mosi_q;
			o.clock_error = err;
			o.tx_busy = tx_busy;
			return o;
		endfunction

		function void note_request(req_word_t r);
			expected_rsp.push_back(predict(r));
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch in %s of response %0d: expected %0h, got %0h",
						name, checked, want, got);
			end
		endfunction

		function void check_response(rsp_word_t got);
			rsp_word_t want;
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response word %0h arrived with none outstanding", got);
				return;
			end
			want = expected_rsp.pop_front();
			compare_field("sclk", 8'(want.sclk), 8'(got.sclk));
			compare_field("mosi", 8'(want.mosi), 8'(got.mosi));
			compare_field("rx_byte", want.rx_byte, got.rx_byte);
			compare_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
			compare_field("rx_done", 8'(want.rx_done), 8'(got.rx_done));
			compare_field("tx_done", 8'(want.tx_done), 8'(got.tx_done));
			compare_field("clock_error", 8'(want.clock_error), 8'(got.clock_error));
			compare_field("tx_busy", 8'(want.tx_busy), 8'(got.tx_busy));
			checked++;
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	// rsp_tracker follows accepted words; gen_tracker runs ahead for stimulus decisions
	spi_line_tracker rsp_tracker = new();
	spi_line_tracker gen_tracker = new();

	int send_idle_pct = 0;
	int stall_pct = 0;
	int counted = 0;
	int words_sent = 0;
	bit start_hold = 1'b0;

	bitbang_spi_master #(.SEND_DEPTH(QUEUE_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Note accepted requests first, then check accepted responses
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				rsp_tracker.note_request(req);
			if (rsp_valid && !rsp_stall)
				rsp_tracker.check_response(rsp);
		end
	end

	// Stall the response side at random; hold off for a long stretch on request
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (start_hold) begin
				start_hold = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				rsp_stall = 1'b1;
				hold_left--;
			end else begin
				rsp_stall = ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	function automatic req_word_t random_word();
		logic [31:0] raw;
		raw = $urandom;
		return raw[$bits(req_word_t)-1:0];
	endfunction

	// Tick with the readback the clock line should show in the current phase
	function automatic req_word_t tick_word();
		req_word_t w;
		w = random_word();
		w.command = CMD_TICK;
		if (gen_tracker.ph == PH_HIGH)
			w.sclk_readback = 1'b1;
		else if (gen_tracker.ph == PH_LOW)
			w.sclk_readback = 1'b0;
		return w;
	endfunction

	function automatic req_word_t push_word(logic [7:0] b, logic last);
		req_word_t w;
		w = random_word();
		w.command = CMD_PUSH;
		w.tx_byte = b;
		w.tx_last = last;
		return w;
	endfunction

	function automatic req_word_t arm_word(logic [7:0] len);
		req_word_t w;
		w = random_word();
		w.command = CMD_ARM;
		w.rx_length = len;
		return w;
	endfunction

	// Offer one request word after a random gap and hold it until accepted
	task automatic issue(req_word_t w, bit counts = 1'b1);
		void'(gen_tracker.predict(w));
		words_sent++;
		if (counts)
			counted++;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = w;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// Stray word: idle command, push or arm, often ignored by the block
	task automatic issue_noise();
		req_word_t w;
		w = random_word();
		case ($urandom_range(0, 2))
			0: w.command = CMD_NONE;
			1: w.command = CMD_PUSH;
			default: begin
				w.command = CMD_ARM;
				if (!gen_tracker.rx_busy)
					w.rx_length = 8'($urandom_range(0, 3));
			end
		endcase
		issue(w, 1'b0);
	endtask

	// Tick until both sender and receiver report done, then a few more
	task automatic drain();
		int extra;
		while (gen_tracker.tx_busy || gen_tracker.rx_busy) begin
			if ($urandom_range(0, 99) < 6)
				issue_noise();
			issue(tick_word());
		end
		extra = $urandom_range(0, 6);
		repeat (extra) issue(tick_word());
	endtask

	// One transfer: queue some bytes, perhaps arm a receive mid-frame, run it out
	task automatic run_transfer();
		int         n;
		int         lead;
		logic [7:0] len;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 5)
				issue_noise();
			issue(push_word(8'($urandom), i == n - 1));
		end
		if ($urandom_range(0, 3) != 0) begin
			lead = $urandom_range(0, 40);
			repeat (lead) issue(tick_word());
			len = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(4, 8))
				: 8'($urandom_range(0, 3));
			issue(arm_word(len));
		end
		drain();
	endtask

	initial begin
		int        idle_tab [4];
		int        stall_tab [4];
		int        quota;
		phase_t    bad_phase;
		req_word_t w;
		idle_tab = '{0, 54, 0, 35};
		stall_tab = '{0, 0, 54, 35};
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, zero-length receive, ignored arm and push
		issue('1);
		issue(arm_word(8'h00));
		issue(arm_word(8'hFF));
		issue(push_word(8'h00, 1'b0));
		issue(push_word(8'hFF, 1'b0));
		issue(push_word(8'hA5, 1'b1));
		issue(push_word(8'h5A, 1'b1));
		drain();

		// Directed: overfill the queue, the last byte is dropped but still arms
		for (int i = 0; i < QUEUE_DEPTH; i++)
			issue(push_word(8'($urandom), 1'b0));
		issue(push_word(8'h3C, 1'b1));
		drain();

		// Directed: receiver armed mid-frame
		repeat (5) issue(tick_word());
		issue(arm_word(8'h01));
		drain();

		// Short receive under a long response hold-off
		start_hold = 1'b1;
		issue(push_word(8'($urandom), 1'b1));
		issue(arm_word(8'h03));
		drain();

		// Random transfers in each idling mix
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			quota = counted + PHASE_WORDS;
			while (counted < quota)
				run_transfer();
		end

		// Finish with a clock readback mismatch; everything after is ignored
		bad_phase = ($urandom_range(0, 1) == 0) ? PH_HIGH : PH_LOW;
		while (gen_tracker.ph != bad_phase)
			issue(tick_word());
		w = tick_word();
		w.sclk_readback = ~w.sclk_readback;
		issue(w);
		repeat (6) issue(random_word());
		req_valid = 1'b0;

		while (rsp_tracker.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Drove %0d request words over four idling mixes and a long hold-off;",
			words_sent);
		$display("%0d responses checked, %0d bytes received, %0d send and %0d receive done.",
			rsp_tracker.checked, rsp_tracker.rx_bytes, rsp_tracker.tx_dones,
			rsp_tracker.rx_dones);
		if (rsp_tracker.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches in total", rsp_tracker.mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin
		#4_000_000;
		$display("timed out with %0d responses outstanding", rsp_tracker.pending());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
rtl/bbspi_pkg.sv
rtl/bbspi_ram.sv
rtl/bitbang_spi_master.sv
verif/tb_bitbang_spi_master.sv
